FILE: hdl/frvr_pkg.sv
// Package for the field/robot vector rotator: CORDIC constants and types.
package frvr_pkg;

   // Angles are carried as a 32-bit fraction of one full turn.
   localparam int TURN_BITS  = 32;
   // Fraction bits kept below the output LSB through the CORDIC.
   localparam int GUARD_BITS = 16;

   typedef logic [TURN_BITS-1:0] turn_type;

   // CORDIC gain K = 0.60725293500888 in Q0.32.
   localparam turn_type GAIN_Q32 = 32'd2608131496;

   // atan(2^-i) in units of 2^-32 turn, truncated.
   localparam turn_type ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
   };

endpackage

FILE: hdl/frvr_req_if.sv
// Request channel interface: input vector, heading and mode.
interface frvr_req_if #(
   parameter int DATA_WIDTH  = 16,
   parameter int ANGLE_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic signed [DATA_WIDTH-1:0]  vec_x;
   logic signed [DATA_WIDTH-1:0]  vec_y;
   logic        [ANGLE_WIDTH-1:0] heading;

   modport source (output valid, mode, vec_x, vec_y, heading, input ready);
   modport sink   (input valid, mode, vec_x, vec_y, heading, output ready);
endinterface

FILE: hdl/frvr_rsp_if.sv
// Response channel interface: rotated vector.
interface frvr_rsp_if #(
   parameter int DATA_WIDTH = 16
);
   logic                        valid;
   logic                        ready;
   logic signed [DATA_WIDTH:0]  rot_x;
   logic signed [DATA_WIDTH:0]  rot_y;

   modport source (output valid, rot_x, rot_y, input ready);
   modport sink   (input valid, rot_x, rot_y, output ready);
endinterface

FILE: hdl/field_robot_vector_rotator_top.sv
// Top level of the field/robot vector rotator: pipelined CORDIC rotation.
//
// Usage
//   req  : vector (vec_x, vec_y, signed Q1.15), heading (binary angle, one
//          turn = 2^ANGLE_WIDTH) and mode (0 = field to robot, rotate by
//          minus the heading; 1 = robot to field, rotate by plus the heading).
//   rsp  : rot_x, rot_y, rounded and saturated to DATA_WIDTH+1 signed bits.
//   One response per request, in order.
// Pipeline and throughput
//   A request passes these registers in order: gain multiply, quadrant fold,
//   one register per CORDIC iteration, round/saturate, output register. One
//   transfer per cycle sustained while rsp does not stall; the rate is set by
//   the one-iteration-per-stage CORDIC pipe.
// Reset
//   Synchronous, active high; clears all valid bits. Nothing else is held.
// Backpressure
//   If rsp is stalled, the output register holds and a one-entry skid buffer
//   takes the next finished result, so req stays ready. Only once the skid is
//   full does the whole pipe freeze and req.ready drop (registered signal).
module field_robot_vector_rotator_top #(
   parameter int DATA_WIDTH    = 16,
   parameter int ANGLE_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   frvr_req_if.sink     req,
   frvr_rsp_if.source   rsp
);
   import frvr_pkg::*;

   // Internal datapath width: guard bits plus headroom for CORDIC growth.
   localparam int W      = DATA_WIDTH + GUARD_BITS + 2;
   localparam int PROD_W = DATA_WIDTH + TURN_BITS + 1;
   localparam int Z_W    = TURN_BITS + 1;
   localparam int RND_W  = W - GUARD_BITS;

   localparam logic signed [RND_W-1:0] OUT_MAX = {2'b00, {DATA_WIDTH{1'b1}}};
   localparam logic signed [RND_W-1:0] OUT_MIN = {2'b11, {DATA_WIDTH{1'b0}}};
   localparam logic signed [W-1:0]     HALF_LSB = W'(1) <<< (GUARD_BITS - 1);

   // Pipe advances only while the skid buffer is empty.
   logic run;

   // ---------------- stage M: gain multiply, angle selection ----------------
   logic signed [PROD_W-1:0]    prod_x, prod_y;
   logic        [ANGLE_WIDTH-1:0] angle_sel;
   turn_type                    turn_in;

   logic                        m_v_ff;
   logic signed [W-1:0]         m_x_ff, m_y_ff;
   turn_type                    m_a_ff;

   assign prod_x    = PROD_W'(req.vec_x) * $signed(PROD_W'(GAIN_Q32));
   assign prod_y    = PROD_W'(req.vec_y) * $signed(PROD_W'(GAIN_Q32));
   assign angle_sel = req.mode ? req.heading : (~req.heading + ANGLE_WIDTH'(1));
   assign turn_in   = TURN_BITS'(angle_sel) << (TURN_BITS - ANGLE_WIDTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (run) begin
         m_v_ff <= req.valid;
      end
      if (run) begin
         // floor(v*K * 2^16), i.e. v*K with GUARD_BITS fraction bits, sign-extended to the datapath width
         m_x_ff <= W'($signed(prod_x[PROD_W-1:GUARD_BITS]));
         m_y_ff <= W'($signed(prod_y[PROD_W-1:GUARD_BITS]));
         m_a_ff <= turn_in;
      end
   end

   // ---------------- stage F: quadrant fold into +/- a quarter turn ----------
   // c_*_ff[0] is the fold output; c_*_ff[k] follows CORDIC iteration k-1.
   logic [CORDIC_STAGES:0]      c_v_ff;
   logic signed [W-1:0]         c_x_ff [CORDIC_STAGES+1];
   logic signed [W-1:0]         c_y_ff [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]       c_z_ff [CORDIC_STAGES+1];

   logic                        fold;
   turn_type                    a_fold;
   logic signed [W-1:0]         f_x_in, f_y_in;
   logic signed [Z_W-1:0]       f_z_in;

   assign fold   = m_a_ff[TURN_BITS-1] ^ m_a_ff[TURN_BITS-2];
   assign a_fold = {m_a_ff[TURN_BITS-1] ^ fold, m_a_ff[TURN_BITS-2:0]};
   assign f_x_in = fold ? -m_x_ff : m_x_ff;
   assign f_y_in = fold ? -m_y_ff : m_y_ff;
   assign f_z_in = {a_fold[TURN_BITS-1], a_fold};

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff[0] <= 1'b0;
      end else if (run) begin
         c_v_ff[0] <= m_v_ff;
      end
      if (run) begin
         c_x_ff[0] <= f_x_in;
         c_y_ff[0] <= f_y_in;
         c_z_ff[0] <= f_z_in;
      end
   end

   // ---------------- CORDIC iterations, one register each -------------------
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
      logic                  dir;
      logic signed [W-1:0]   dx, dy, x_in, y_in;
      logic signed [Z_W-1:0] step, z_in;

      assign dir  = ~c_z_ff[i][Z_W-1];
      assign dx   = c_y_ff[i] >>> i;
      assign dy   = c_x_ff[i] >>> i;
      assign step = {1'b0, ATAN_TURNS[i]};
      assign x_in = dir ? (c_x_ff[i] - dx)   : (c_x_ff[i] + dx);
      assign y_in = dir ? (c_y_ff[i] + dy)   : (c_y_ff[i] - dy);
      assign z_in = dir ? (c_z_ff[i] - step) : (c_z_ff[i] + step);

      always_ff @(posedge clock) begin
         if (reset) begin
            c_v_ff[i+1] <= 1'b0;
         end else if (run) begin
            c_v_ff[i+1] <= c_v_ff[i];
         end
         if (run) begin
            c_x_ff[i+1] <= x_in;
            c_y_ff[i+1] <= y_in;
            c_z_ff[i+1] <= z_in;
         end
      end
   end

   // ---------------- stage R: round half up, saturate ----------------------
   logic signed [W-1:0]          sum_x, sum_y;
   logic signed [RND_W-1:0]      q_x, q_y;
   logic signed [DATA_WIDTH:0]   r_x_in, r_y_in;

   logic                         r_v_ff;
   logic signed [DATA_WIDTH:0]   r_x_ff, r_y_ff;

   assign sum_x = c_x_ff[CORDIC_STAGES] + HALF_LSB;
   assign sum_y = c_y_ff[CORDIC_STAGES] + HALF_LSB;
   assign q_x   = sum_x[W-1:GUARD_BITS];
   assign q_y   = sum_y[W-1:GUARD_BITS];

   always_comb begin
      if (q_x > OUT_MAX)      r_x_in = OUT_MAX[DATA_WIDTH:0];
      else if (q_x < OUT_MIN) r_x_in = OUT_MIN[DATA_WIDTH:0];
      else                    r_x_in = q_x[DATA_WIDTH:0];
      if (q_y > OUT_MAX)      r_y_in = OUT_MAX[DATA_WIDTH:0];
      else if (q_y < OUT_MIN) r_y_in = OUT_MIN[DATA_WIDTH:0];
      else                    r_y_in = q_y[DATA_WIDTH:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
      end else if (run) begin
         r_v_ff <= c_v_ff[CORDIC_STAGES];
      end
      if (run) begin
         r_x_ff <= r_x_in;
         r_y_ff <= r_y_in;
      end
   end

   // ---------------- output register and skid buffer -----------------------
   logic                         o_v_ff, o_v_in;
   logic signed [DATA_WIDTH:0]   o_x_ff, o_y_ff, o_x_in, o_y_in;
   logic                         s_v_ff, s_v_in;
   logic signed [DATA_WIDTH:0]   s_x_ff, s_y_ff, s_x_in, s_y_in;

   assign run = ~s_v_ff;

   always_comb begin
      o_v_in = o_v_ff;
      o_x_in = o_x_ff;
      o_y_in = o_y_ff;
      s_v_in = s_v_ff;
      s_x_in = s_x_ff;
      s_y_in = s_y_ff;
      if (s_v_ff) begin
         // pipe frozen; drain skid into the output register
         if (rsp.ready) begin
            o_v_in = 1'b1;
            o_x_in = s_x_ff;
            o_y_in = s_y_ff;
            s_v_in = 1'b0;
         end
      end else if (!o_v_ff || rsp.ready) begin
         o_v_in = r_v_ff;
         o_x_in = r_x_ff;
         o_y_in = r_y_ff;
      end else if (r_v_ff) begin
         // output stalled: park the arriving result
         s_v_in = 1'b1;
         s_x_in = r_x_ff;
         s_y_in = r_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
         s_v_ff <= 1'b0;
      end else begin
         o_v_ff <= o_v_in;
         s_v_ff <= s_v_in;
      end
      o_x_ff <= o_x_in;
      o_y_ff <= o_y_in;
      s_x_ff <= s_x_in;
      s_y_ff <= s_y_in;
   end

   assign req.ready = run;
   assign rsp.valid = o_v_ff;
   assign rsp.rot_x = o_x_ff;
   assign rsp.rot_y = o_y_ff;

   // ---------------- assertions ---------------------------------------------
   // Skid only ever holds a result behind a waiting output.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      s_v_ff |-> o_v_ff)
      else $error("skid buffer full while output register empty");

   // A result reaching a stalled output must be parked, not dropped.
   a_park_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!s_v_ff && o_v_ff && !rsp.ready && r_v_ff) |=> s_v_ff)
      else $error("finished result lost at stalled output");

   // While the skid is full and the receiver stalls, the pipe stays frozen.
   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      (s_v_ff && !rsp.ready) |=> ($stable(c_v_ff) && $stable(r_v_ff) && $stable(m_v_ff)))
      else $error("pipeline moved while skid buffer full");

endmodule

FILE: tb/sv/field_robot_vector_rotator_top_tb.sv
// Testbench for the field/robot vector rotator: directed and random vectors, checked in order.

// Works out each rotated vector independently and checks the responses in order.
class rotation_scoreboard;
   localparam int DATA_W  = 16;
   localparam int ANGLE_W = 16;
   localparam int STAGES  = 16;
   localparam int GUARD   = frvr_pkg::GUARD_BITS;
   localparam longint GAIN    = longint'({32'd0, frvr_pkg::GAIN_Q32});
   localparam longint OUT_MAX = (64'sd1 <<< DATA_W) - 1;
   localparam longint OUT_MIN = -(64'sd1 <<< DATA_W);

   typedef struct {
      logic signed [DATA_W:0] rot_x;
      logic signed [DATA_W:0] rot_y;
   } rotated_vec_type;

   rotated_vec_type awaited[$];
   int              mismatches;
   int              checked;

   function new();
      mismatches = 0;
      checked    = 0;
   endfunction

   // Rotation by +/- heading, gain applied up front, quadrant folded into +/-90 deg.
   function rotated_vec_type rotate_vector(bit to_field, logic signed [DATA_W-1:0] vx,
                                           logic signed [DATA_W-1:0] vy,
                                           logic [ANGLE_W-1:0] heading);
      logic [ANGLE_W-1:0] angle;
      logic [31:0]        turn;
      longint             x, y, z, nx, ny, step;
      int                 i;
      rotated_vec_type    res;
      angle = to_field ? heading : ANGLE_W'(-heading);
      turn  = {angle, {(32-ANGLE_W){1'b0}}};
      x = (longint'(vx) * GAIN) >>> (32 - GUARD);
      y = (longint'(vy) * GAIN) >>> (32 - GUARD);
      // second and third quadrants: turn half way round and flip the vector
      if (turn[31] != turn[30]) begin
         x    = -x;
         y    = -y;
         turn = turn + 32'h8000_0000;
      end
      z = int'(turn);
      for (i = 0; i < STAGES; i++) begin
         step = longint'({32'd0, frvr_pkg::ATAN_TURNS[i]});
         if (z >= 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z  = z - step;
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z  = z + step;
         end
         x = nx;
         y = ny;
      end
      x = (x + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
      y = (y + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
      if (x > OUT_MAX) x = OUT_MAX;
      if (x < OUT_MIN) x = OUT_MIN;
      if (y > OUT_MAX) y = OUT_MAX;
      if (y < OUT_MIN) y = OUT_MIN;
      res.rot_x = x[DATA_W:0];
      res.rot_y = y[DATA_W:0];
      return res;
   endfunction

   function void note_request(bit to_field, logic signed [DATA_W-1:0] vx,
                              logic signed [DATA_W-1:0] vy, logic [ANGLE_W-1:0] heading);
      awaited.push_back(rotate_vector(to_field, vx, vy, heading));
   endfunction

   function void check_result(logic signed [DATA_W:0] rx, logic signed [DATA_W:0] ry);
      rotated_vec_type exp;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected result rot_x=%0d rot_y=%0d", $time, rx, ry);
         mismatches++;
         return;
      end
      exp = awaited.pop_front();
      checked++;
      if (rx !== exp.rot_x) begin
         $display("%0t: rot_x mismatch, expected %0d, got %0d", $time, exp.rot_x, rx);
         mismatches++;
      end
      if (ry !== exp.rot_y) begin
         $display("%0t: rot_y mismatch, expected %0d, got %0d", $time, exp.rot_y, ry);
         mismatches++;
      end
   endfunction
endclass

module field_robot_vector_rotator_top_tb;
   localparam int DATA_W      = 16;
   localparam int ANGLE_W     = 16;
   localparam int STAGES      = 16;
   // request to response, in cycles
   localparam int LATENCY     = STAGES + 4;
   localparam int RANDOM_ITEMS = 2000;
   // last stretch runs with both sides always willing
   localparam int STEADY_ITEMS = 300;
   // long receiver hold-off, well past pipe depth plus skid
   localparam int SQUEEZE_CYCLES = 80;
   localparam int SQUEEZE_AT     = 600;
   localparam int SQUEEZE_ITEMS  = 150;

   logic clock;
   logic reset;

   frvr_req_if #(.DATA_WIDTH(DATA_W), .ANGLE_WIDTH(ANGLE_W)) req_ch ();
   frvr_rsp_if #(.DATA_WIDTH(DATA_W))                        rsp_ch ();

   field_robot_vector_rotator_top #(
      .DATA_WIDTH   (DATA_W),
      .ANGLE_WIDTH  (ANGLE_W),
      .CORDIC_STAGES(STAGES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch.sink),
      .rsp  (rsp_ch.source)
   );

   rotation_scoreboard rotations;

   // Knobs shared between the stimulus and the receiver; changed with NBAs at edges.
   int  req_idle_pct;
   int  rsp_idle_pct;
   bit  steady;
   bit  squeeze_req;
   bit  squeeze_done;
   bit  squeeze_on;     // sender offers back to back while the receiver holds off
   int  stall_left;
   int  sent;
   int  directed;
   int  input_stalls;   // cycles where a request was offered but not taken

   always #5 clock = ~clock;

   // Hard stop, several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // --------------------------------------------------------------------
   // Response side: check every transfer, then decide ready for the next
   // cycle. Random idle bursts, one long hold-off on request, and none at
   // all once the run is in its steady tail.
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         rotations.check_result(rsp_ch.rot_x, rsp_ch.rot_y);
      if (!reset && req_ch.valid && !req_ch.ready)
         input_stalls <= input_stalls + 1;

      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (squeeze_req && !squeeze_done) begin
         // own count of the long stall; the pipe and skid fill and req stalls
         squeeze_done <= 1'b1;
         stall_left   <= SQUEEZE_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(99) < rsp_idle_pct) begin
         stall_left   <= $urandom_range(11, 0);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // One request transfer. Valid stays up into the next call unless an idle
   // burst follows, so it is never dropped and raised in the same step.
   task automatic send_vector(input bit to_field, input logic signed [DATA_W-1:0] vx,
                              input logic signed [DATA_W-1:0] vy,
                              input logic [ANGLE_W-1:0] heading);
      req_ch.valid   <= 1'b1;
      req_ch.mode    <= to_field;
      req_ch.vec_x   <= vx;
      req_ch.vec_y   <= vy;
      req_ch.heading <= heading;
      do @(posedge clock); while (!req_ch.ready);
      rotations.note_request(to_field, vx, vy, heading);
      sent++;
      if (!steady && !squeeze_on && $urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
   endtask

   // Full-scale and near-zero components, the corners of the input range.
   function automatic logic signed [DATA_W-1:0] pick_extreme();
      case ($urandom_range(5))
         0:       return -16'sd32768;
         1:       return -16'sd32767;
         2:       return -16'sd1;
         3:       return 16'sd0;
         4:       return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   // Random request: mostly uniform, some full-scale vectors, some headings
   // close to the quadrant boundaries where the fold switches.
   task automatic send_random_vector();
      bit                        to_field;
      logic signed [DATA_W-1:0]  vx;
      logic signed [DATA_W-1:0]  vy;
      logic [ANGLE_W-1:0]        heading;
      int                        pick;
      to_field = 1'($urandom_range(1));
      vx       = DATA_W'($urandom);
      vy       = DATA_W'($urandom);
      heading  = ANGLE_W'($urandom);
      pick     = $urandom_range(99);
      if (pick >= 70 && pick < 85) begin
         vx = pick_extreme();
         vy = pick_extreme();
      end else if (pick >= 85) begin
         heading = ANGLE_W'({$urandom_range(3), {(ANGLE_W-2){1'b0}}}
                            + $urandom_range(4) - 2);
      end
      send_vector(to_field, vx, vy, heading);
   endtask

   initial begin
      int n;
      rotations      = new();
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.mode    = 1'b0;
      req_ch.vec_x   = '0;
      req_ch.vec_y   = '0;
      req_ch.heading = '0;
      rsp_ch.ready   = 1'b0;
      req_idle_pct   = 0;
      rsp_idle_pct   = 0;
      steady         = 1'b0;
      squeeze_req    = 1'b0;
      squeeze_done   = 1'b0;
      squeeze_on     = 1'b0;
      sent           = 0;
      input_stalls   = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed: zero, unit axes at each quarter turn, both modes,
      // full-scale corners, headings either side of each quadrant boundary.
      send_vector(1'b0, 16'sd0, 16'sd0, 16'd0);
      send_vector(1'b1, 16'sd32767, 16'sd0, 16'd0);
      send_vector(1'b1, 16'sd32767, 16'sd0, 16'd16384);
      send_vector(1'b1, 16'sd32767, 16'sd0, 16'd32768);
      send_vector(1'b1, 16'sd32767, 16'sd0, 16'd49152);
      send_vector(1'b0, 16'sd32767, 16'sd0, 16'd16384);
      send_vector(1'b0, -16'sd32768, 16'sd0, 16'd16384);
      send_vector(1'b1, 16'sd0, -16'sd32768, 16'd65535);
      send_vector(1'b0, 16'sd0, 16'sd32767, 16'd1);
      send_vector(1'b1, 16'sd32767, 16'sd32767, 16'd8192);
      send_vector(1'b0, -16'sd32768, -16'sd32768, 16'd8192);
      send_vector(1'b1, -16'sd32768, -16'sd32768, 16'd40960);
      send_vector(1'b0, 16'sd32767, -16'sd32768, 16'd24576);
      send_vector(1'b1, -16'sd32768, 16'sd32767, 16'd57344);
      send_vector(1'b0, 16'sd1, -16'sd1, 16'd32767);
      send_vector(1'b1, -16'sd1, 16'sd1, 16'd32769);
      send_vector(1'b1, 16'sd32767, 16'sd32767, 16'd16383);
      send_vector(1'b1, 16'sd32767, 16'sd32767, 16'd16385);
      send_vector(1'b0, -16'sd32768, 16'sd32767, 16'd49151);
      send_vector(1'b0, -16'sd32768, 16'sd32767, 16'd49153);
      send_vector(1'b1, -16'sd32768, -16'sd32768, 16'd0);
      send_vector(1'b0, 16'sd32767, 16'sd32767, 16'd32768);
      directed = sent;

      // ---- random: idle mix re-rolled every 250 transfers, one long
      // receiver squeeze, and a clean back-to-back tail.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 250 == 0) begin
            case ($urandom_range(3))
               0:       req_idle_pct <= 0;
               1:       req_idle_pct <= 5;
               2:       req_idle_pct <= 20;
               default: req_idle_pct <= 40;
            endcase
            case ($urandom_range(3))
               0:       rsp_idle_pct <= 0;
               1:       rsp_idle_pct <= 5;
               2:       rsp_idle_pct <= 20;
               default: rsp_idle_pct <= 40;
            endcase
         end
         if (n == SQUEEZE_AT) begin
            squeeze_on  <= 1'b1;
            squeeze_req <= 1'b1;
         end
         if (n == SQUEEZE_AT + SQUEEZE_ITEMS)
            squeeze_on <= 1'b0;
         if (n == RANDOM_ITEMS - STEADY_ITEMS)
            steady <= 1'b1;
         send_random_vector();
      end
      req_ch.valid <= 1'b0;

      // drain, then give any stray result time to show up
      while (rotations.awaited.size() != 0)
         @(posedge clock);
      repeat (3 * LATENCY) @(posedge clock);

      $display("Rotated %0d vectors (%0d directed) in both modes across all quadrants; %0d checked.",
               sent, directed, rotations.checked);
      $display("Requests were held off for %0d cycles by output backpressure.", input_stalls);
      if (rotations.mismatches == 0 && rotations.awaited.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
